// ===== hdl/hsp_pkg.sv =====
// Package for the Hermite spline point pipeline.
// Holds the fixed-point widths, stage payload types and step functions.
// Used by hdl/hermite_spline_point.sv; depends on nothing.
package hsp_pkg;

   localparam int CB = 16;
   localparam int TF = 16;
   localparam int FB = CB / 2;
   localparam int DIV_STEPS = 2 * (FB + 1) + 3;
   localparam int Q_BITS = DIV_STEPS;
   localparam int R_BITS = 2 * CB + 2;
   localparam int SQRT_STEPS = (Q_BITS + 1) / 2;
   localparam int RES_BITS = Q_BITS + 1;
   localparam int C_BITS = FB + 2;
   localparam int W_BITS = TF + 4;
   localparam int P_BITS = W_BITS + CB + 1;
   localparam int A_BITS = P_BITS + 2;
   localparam int O_BITS = A_BITS - TF - 1;

   typedef logic signed [CB-1:0] coord_type;
   typedef logic signed [CB:0] diff_type;
   typedef logic signed [W_BITS-1:0] weight_type;

   typedef struct packed {
      coord_type sx;
      coord_type sy;
      coord_type ex;
      coord_type ey;
      diff_type d0x;
      diff_type d0y;
      diff_type d1x;
      diff_type d1y;
      logic negx;
      logic negy;
      logic zero;
      logic first;
      logic last;
      weight_type h00;
      weight_type h10;
      weight_type h01;
      weight_type h11;
   } side_type;

   typedef struct packed {
      side_type side;
      logic [CB-1:0] ux;
      logic [CB-1:0] uy;
      logic [TF:0] t;
      logic [2*CB-1:0] sqx;
      logic [2*CB-1:0] sqy;
      logic [2*CB:0] len2;
      logic [2*TF+1:0] tt;
      logic [TF:0] t2;
      logic [2*TF+1:0] t2t;
      logic [TF:0] t3;
   } front_type;

   typedef struct packed {
      side_type side;
      logic [2*CB:0] len2;
      logic [R_BITS-1:0] rx;
      logic [R_BITS-1:0] ry;
      logic [Q_BITS-1:0] qx;
      logic [Q_BITS-1:0] qy;
   } div_type;

   typedef struct packed {
      side_type side;
      logic [Q_BITS-1:0] remx;
      logic [Q_BITS-1:0] remy;
      logic [RES_BITS-1:0] resx;
      logic [RES_BITS-1:0] resy;
   } root_type;

   typedef struct packed {
      logic [R_BITS-1:0] r;
      logic b;
   } div_step_type;

   typedef struct packed {
      logic [Q_BITS-1:0] rem;
      logic [RES_BITS-1:0] res;
   } root_step_type;

   typedef struct packed {
      side_type side;
      diff_type m0x;
      diff_type m0y;
      diff_type m1x;
      diff_type m1y;
   } tan_type;

   typedef struct packed {
      logic signed [P_BITS-1:0] p00x;
      logic signed [P_BITS-1:0] p10x;
      logic signed [P_BITS-1:0] p01x;
      logic signed [P_BITS-1:0] p11x;
      logic signed [P_BITS-1:0] p00y;
      logic signed [P_BITS-1:0] p10y;
      logic signed [P_BITS-1:0] p01y;
      logic signed [P_BITS-1:0] p11y;
   } prod_type;

   function automatic div_step_type div_step(input logic [R_BITS-1:0] r,
                                             input logic [2*CB:0] len2);
      div_step_type s;
      s.b = (r >= R_BITS'(len2));
      s.r = s.b ? r - R_BITS'(len2) : r;
      return s;
   endfunction

   function automatic root_step_type root_step(input logic [Q_BITS-1:0] rem,
                                               input logic [RES_BITS-1:0] res,
                                               input logic [RES_BITS-1:0] bitv);
      root_step_type s;
      logic [RES_BITS-1:0] trial;
      trial = res + bitv;
      if (RES_BITS'(rem) >= trial) begin
         s.rem = Q_BITS'(RES_BITS'(rem) - trial);
         s.res = (res >> 1) + bitv;
      end else begin
         s.rem = rem;
         s.res = res >> 1;
      end
      return s;
   endfunction

endpackage

// ===== hdl/hermite_spline_point.sv =====
// Top level of the Hermite spline point pipeline.
// Depends on hdl/hsp_pkg.sv for widths, stage types and step functions.
//
// Usage: each req_ word carries one segment (start, end), its neighbors
// (prev, next), the first and last flags and the parameter t in Q1.16.
// Each accepted word yields exactly one rsp_ word with the curve point in
// Q8.8 and a flag that is set when either coordinate was clipped.
// From the accepting edge to rsp_valid the word passes six front
// stages for t powers, weights and chord squares, 21 stages of restoring
// division (one quotient bit each), 11 stages of square root (one result
// bit each) and four stages for tangents, products, sums and rounding.
// Throughput is one word per cycle when rsp_ready stays high.
// The whole pipeline advances together; when rsp_valid is high and
// rsp_ready is low it holds every stage and drops req_ready, so no word is
// lost or repeated. Bubbles travel as cleared valid bits.
// Reset clears all valid bits; the block needs no other setup.
module hermite_spline_point
   import hsp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [CB-1:0] req_prev_x,
   input  logic signed [CB-1:0] req_prev_y,
   input  logic signed [CB-1:0] req_start_x,
   input  logic signed [CB-1:0] req_start_y,
   input  logic signed [CB-1:0] req_end_x,
   input  logic signed [CB-1:0] req_end_y,
   input  logic signed [CB-1:0] req_next_x,
   input  logic signed [CB-1:0] req_next_y,
   input  logic req_is_first,
   input  logic req_is_last,
   input  logic [TF:0] req_param_t,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [CB-1:0] rsp_curve_x,
   output logic signed [CB-1:0] rsp_curve_y,
   output logic rsp_saturated
);

   localparam logic [TF:0] T_ONE = (TF+1)'(1) << TF;
   localparam logic signed [W_BITS-1:0] W_ONE = W_BITS'(1) << TF;
   localparam logic signed [O_BITS-1:0] O_HI = O_BITS'((1 << (CB - 1)) - 1);
   localparam logic signed [O_BITS-1:0] O_LO = -O_BITS'(1 << (CB - 1));

   logic adv;
   logic [5:0] fr_valid_ff;
   front_type fr_ff [6];
   front_type fr_in [6];
   logic [DIV_STEPS-1:0] dv_valid_ff;
   div_type dv_ff [DIV_STEPS];
   div_type dv_in [DIV_STEPS];
   logic [SQRT_STEPS-1:0] rt_valid_ff;
   root_type rt_ff [SQRT_STEPS];
   root_type rt_in [SQRT_STEPS];
   logic tn_valid_ff, pr_valid_ff, sm_valid_ff, rsp_valid_ff;
   tan_type tn_ff, tn_in;
   prod_type pr_ff, pr_in;
   logic signed [A_BITS-1:0] smx_ff, smy_ff, smx_in, smy_in;
   logic signed [CB-1:0] cx_ff, cy_ff, cx_in, cy_in;
   logic sat_ff, sat_in;
   logic [C_BITS-1:0] chx, chy;
   diff_type uxs, uys;
   logic signed [O_BITS-1:0] ox, oy;

   assign adv = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // Front stages.
   always_comb begin
      logic signed [CB:0] dx, dy;
      logic signed [W_BITS-1:0] w1, w2, w3;
      fr_in[0] = '0;
      fr_in[0].side.sx = req_start_x;
      fr_in[0].side.sy = req_start_y;
      fr_in[0].side.ex = req_end_x;
      fr_in[0].side.ey = req_end_y;
      fr_in[0].side.d0x = (CB+1)'(req_end_x) - (CB+1)'(req_prev_x);
      fr_in[0].side.d0y = (CB+1)'(req_end_y) - (CB+1)'(req_prev_y);
      fr_in[0].side.d1x = (CB+1)'(req_next_x) - (CB+1)'(req_start_x);
      fr_in[0].side.d1y = (CB+1)'(req_next_y) - (CB+1)'(req_start_y);
      dx = (CB+1)'(req_end_x) - (CB+1)'(req_start_x);
      dy = (CB+1)'(req_end_y) - (CB+1)'(req_start_y);
      fr_in[0].side.negx = dx[CB];
      fr_in[0].side.negy = dy[CB];
      fr_in[0].ux = dx[CB] ? CB'(-dx) : CB'(dx);
      fr_in[0].uy = dy[CB] ? CB'(-dy) : CB'(dy);
      fr_in[0].side.zero = (dx == '0) && (dy == '0);
      fr_in[0].side.first = req_is_first;
      fr_in[0].side.last = req_is_last;
      fr_in[0].t = (req_param_t > T_ONE) ? T_ONE : req_param_t;

      fr_in[1] = fr_ff[0];
      fr_in[1].sqx = (2*CB)'(fr_ff[0].ux) * (2*CB)'(fr_ff[0].ux);
      fr_in[1].sqy = (2*CB)'(fr_ff[0].uy) * (2*CB)'(fr_ff[0].uy);
      fr_in[1].tt = (2*TF+2)'(fr_ff[0].t) * (2*TF+2)'(fr_ff[0].t);

      fr_in[2] = fr_ff[1];
      fr_in[2].len2 = (2*CB+1)'(fr_ff[1].sqx) + (2*CB+1)'(fr_ff[1].sqy);
      fr_in[2].t2 = (TF+1)'((fr_ff[1].tt + ((2*TF+2)'(1) << (TF - 1))) >> TF);

      fr_in[3] = fr_ff[2];
      fr_in[3].t2t = (2*TF+2)'(fr_ff[2].t2) * (2*TF+2)'(fr_ff[2].t);

      fr_in[4] = fr_ff[3];
      fr_in[4].t3 = (TF+1)'((fr_ff[3].t2t + ((2*TF+2)'(1) << (TF - 1))) >> TF);

      fr_in[5] = fr_ff[4];
      w1 = $signed(W_BITS'(fr_ff[4].t));
      w2 = $signed(W_BITS'(fr_ff[4].t2));
      w3 = $signed(W_BITS'(fr_ff[4].t3));
      fr_in[5].side.h00 = (w3 <<< 1) - (w2 + (w2 <<< 1)) + W_ONE;
      fr_in[5].side.h10 = w3 - (w2 <<< 1) + w1;
      fr_in[5].side.h01 = (w2 + (w2 <<< 1)) - (w3 <<< 1);
      fr_in[5].side.h11 = w3 - w2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= '0;
      end else if (adv) begin
         fr_valid_ff <= {fr_valid_ff[4:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 6; i++) begin
            fr_ff[i] <= fr_in[i];
         end
      end
   end

   // Restoring division, one quotient bit per stage.
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      div_type src;
      logic [R_BITS-1:0] rxs, rys;
      div_step_type sx_in, sy_in;
      if (j == 0) begin : g_head
         always_comb begin
            src = '0;
            src.side = fr_ff[5].side;
            src.len2 = fr_ff[5].len2;
            rxs = R_BITS'(fr_ff[5].sqx);
            rys = R_BITS'(fr_ff[5].sqy);
         end
      end else begin : g_body
         always_comb begin
            src = dv_ff[j-1];
            rxs = {dv_ff[j-1].rx[R_BITS-2:0], 1'b0};
            rys = {dv_ff[j-1].ry[R_BITS-2:0], 1'b0};
         end
      end
      always_comb begin
         sx_in = div_step(rxs, src.len2);
         sy_in = div_step(rys, src.len2);
         dv_in[j] = src;
         dv_in[j].rx = sx_in.r;
         dv_in[j].ry = sy_in.r;
         dv_in[j].qx = {src.qx[Q_BITS-2:0], sx_in.b};
         dv_in[j].qy = {src.qy[Q_BITS-2:0], sy_in.b};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff <= '0;
      end else if (adv) begin
         dv_valid_ff <= {dv_valid_ff[DIV_STEPS-2:0], fr_valid_ff[5]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < DIV_STEPS; j++) begin
            dv_ff[j] <= dv_in[j];
         end
      end
   end

   // Digit-by-digit square root, one result bit per stage.
   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_root
      localparam logic [RES_BITS-1:0] BITV = RES_BITS'(1) << (2 * (SQRT_STEPS - 1 - i));
      root_type src;
      root_step_type sx_in, sy_in;
      if (i == 0) begin : g_head
         always_comb begin
            src.side = dv_ff[DIV_STEPS-1].side;
            src.remx = dv_ff[DIV_STEPS-1].qx;
            src.remy = dv_ff[DIV_STEPS-1].qy;
            src.resx = '0;
            src.resy = '0;
         end
      end else begin : g_body
         assign src = rt_ff[i-1];
      end
      always_comb begin
         sx_in = root_step(src.remx, src.resx, BITV);
         sy_in = root_step(src.remy, src.resy, BITV);
         rt_in[i] = src;
         rt_in[i].remx = sx_in.rem;
         rt_in[i].remy = sy_in.rem;
         rt_in[i].resx = sx_in.res;
         rt_in[i].resy = sy_in.res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_valid_ff <= '0;
      end else if (adv) begin
         rt_valid_ff <= {rt_valid_ff[SQRT_STEPS-2:0], dv_valid_ff[DIV_STEPS-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < SQRT_STEPS; i++) begin
            rt_ff[i] <= rt_in[i];
         end
      end
   end

   // Tangents, products, sums and rounding.
   always_comb begin
      side_type s;
      s = rt_ff[SQRT_STEPS-1].side;
      chx = C_BITS'((rt_ff[SQRT_STEPS-1].resx + RES_BITS'(1)) >> 1);
      chy = C_BITS'((rt_ff[SQRT_STEPS-1].resy + RES_BITS'(1)) >> 1);
      if (s.zero) begin
         uxs = '0;
         uys = '0;
      end else begin
         uxs = s.negx ? -$signed((CB+1)'(chx)) : $signed((CB+1)'(chx));
         uys = s.negy ? -$signed((CB+1)'(chy)) : $signed((CB+1)'(chy));
      end
      tn_in.side = s;
      tn_in.m0x = s.first ? uxs : s.d0x;
      tn_in.m0y = s.first ? uys : s.d0y;
      tn_in.m1x = s.last ? uxs : s.d1x;
      tn_in.m1y = s.last ? uys : s.d1y;
   end

   always_comb begin
      diff_type sx2, sy2, ex2, ey2;
      sx2 = {tn_ff.side.sx, 1'b0};
      sy2 = {tn_ff.side.sy, 1'b0};
      ex2 = {tn_ff.side.ex, 1'b0};
      ey2 = {tn_ff.side.ey, 1'b0};
      pr_in.p00x = tn_ff.side.h00 * sx2;
      pr_in.p10x = tn_ff.side.h10 * tn_ff.m0x;
      pr_in.p01x = tn_ff.side.h01 * ex2;
      pr_in.p11x = tn_ff.side.h11 * tn_ff.m1x;
      pr_in.p00y = tn_ff.side.h00 * sy2;
      pr_in.p10y = tn_ff.side.h10 * tn_ff.m0y;
      pr_in.p01y = tn_ff.side.h01 * ey2;
      pr_in.p11y = tn_ff.side.h11 * tn_ff.m1y;
   end

   assign smx_in = A_BITS'(pr_ff.p00x) + A_BITS'(pr_ff.p10x)
                 + A_BITS'(pr_ff.p01x) + A_BITS'(pr_ff.p11x);
   assign smy_in = A_BITS'(pr_ff.p00y) + A_BITS'(pr_ff.p10y)
                 + A_BITS'(pr_ff.p01y) + A_BITS'(pr_ff.p11y);

   always_comb begin
      logic signed [A_BITS-1:0] rndx, rndy;
      rndx = (smx_ff + (A_BITS'(1) <<< TF)) >>> (TF + 1);
      rndy = (smy_ff + (A_BITS'(1) <<< TF)) >>> (TF + 1);
      ox = O_BITS'(rndx);
      oy = O_BITS'(rndy);
      sat_in = 1'b0;
      cx_in = CB'(ox);
      cy_in = CB'(oy);
      if (ox > O_HI) begin
         cx_in = CB'(O_HI);
         sat_in = 1'b1;
      end else if (ox < O_LO) begin
         cx_in = CB'(O_LO);
         sat_in = 1'b1;
      end
      if (oy > O_HI) begin
         cy_in = CB'(O_HI);
         sat_in = 1'b1;
      end else if (oy < O_LO) begin
         cy_in = CB'(O_LO);
         sat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tn_valid_ff <= 1'b0;
         pr_valid_ff <= 1'b0;
         sm_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         tn_valid_ff <= rt_valid_ff[SQRT_STEPS-1];
         pr_valid_ff <= tn_valid_ff;
         sm_valid_ff <= pr_valid_ff;
         rsp_valid_ff <= sm_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tn_ff <= tn_in;
         pr_ff <= pr_in;
         smx_ff <= smx_in;
         smy_ff <= smy_in;
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_curve_x = cx_ff;
   assign rsp_curve_y = cy_ff;
   assign rsp_saturated = sat_ff;

   // The unit chord component never exceeds one in the tangent format.
   a_chord_range: assert property (@(posedge clock) disable iff (reset)
      (rt_valid_ff[SQRT_STEPS-1] && !rt_ff[SQRT_STEPS-1].side.zero) |->
         (chx <= (C_BITS'(1) << (FB + 1))))
      else $error("unit chord component out of range");

   // A clipped result sits on a rail of the coordinate range.
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && sat_ff) |->
         (cx_ff == CB'(O_HI) || cx_ff == CB'(O_LO) ||
          cy_ff == CB'(O_HI) || cy_ff == CB'(O_LO)))
      else $error("saturation flag without a clipped coordinate");

   // Reset leaves no word in flight at the output.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result valid right after reset");

   // A held pipeline keeps the waiting result.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(cx_ff) && $stable(cy_ff)))
      else $error("stalled result changed");

endmodule
